/* rtl/fbc_pkg.sv */
// Shared types, codes and plane tables for the frustum box culling unit.
package fbc_pkg;

  // Geometry counts
  localparam int PLANE_COUNT = 6;
  localparam int AXIS_COUNT  = 3;
  localparam int ROW_COUNT   = 4;
  localparam int MAT_DEPTH   = 16;

  // Request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_e;

  // How the second matrix row joins the first one in a plane
  typedef enum logic [1:0] {
    PAIR_NONE = 2'd0,
    PAIR_ADD  = 2'd1,
    PAIR_SUB  = 2'd2
  } pair_op_e;

  // Planes in order: left, right, bottom, top, near, far
  localparam logic [1:0] PLANE_ROW_A [PLANE_COUNT] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3};
  localparam logic [1:0] PLANE_ROW_B [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2};
  localparam pair_op_e   PLANE_OP    [PLANE_COUNT] =
    '{PAIR_ADD, PAIR_SUB, PAIR_ADD, PAIR_SUB, PAIR_NONE, PAIR_SUB};

  // Stage load enables handed to each plane evaluator
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } pipe_en_t;

endpackage

/* rtl/fbc_plane.sv */
// Pipelined evaluation of one clip plane against a box: products, sums, sign tests.
module fbc_plane import fbc_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  pipe_en_t                      en_i,
  input  logic signed [COORD_WIDTH:0]   coef_i [ROW_COUNT],
  input  logic        [COORD_WIDTH:0]   abs_i  [AXIS_COUNT],
  input  logic signed [COORD_WIDTH:0]   csum_i [AXIS_COUNT],
  input  logic signed [COORD_WIDTH:0]   cext_i [AXIS_COUNT],
  output logic                          outside_o,
  output logic                          intersect_o
);

  localparam int PW      = 2 * COORD_WIDTH + 2;
  localparam int OFS_W   = COORD_WIDTH + FRACTION_BITS + 2;
  localparam int SW      = ((PW > OFS_W) ? PW : OFS_W) + 2;

  logic signed [PW-1:0]        prod_n_d [AXIS_COUNT];
  logic signed [PW-1:0]        prod_a_d [AXIS_COUNT];
  logic signed [PW-1:0]        prod_n_q [AXIS_COUNT];
  logic signed [PW-1:0]        prod_a_q [AXIS_COUNT];
  logic signed [COORD_WIDTH:0] ofs_q;
  logic signed [SW-1:0]        dist_d;
  logic signed [SW-1:0]        absd_d;
  logic signed [SW-1:0]        dist_q;
  logic signed [SW-1:0]        absd_q;
  logic signed [SW:0]          low_sum;
  logic signed [SW:0]          high_diff;

  // Form the normal and extent products, one multiplier each
  always_comb begin
    logic signed [COORD_WIDTH+1:0] abs_ext;
    abs_ext = '0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      abs_ext     = signed'({1'b0, abs_i[k]});
      prod_n_d[k] = coef_i[k] * csum_i[k];
      prod_a_d[k] = abs_ext * cext_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_n_q <= prod_n_d;
      prod_a_q <= prod_a_d;
      ofs_q    <= coef_i[ROW_COUNT-1];
    end
  end

  // Accumulate the signed distance and the projected extent
  always_comb begin
    dist_d = (SW'(ofs_q) <<< (FRACTION_BITS + 1))
           + SW'(prod_n_q[0]) + SW'(prod_n_q[1]) + SW'(prod_n_q[2]);
    absd_d = SW'(prod_a_q[0]) + SW'(prod_a_q[1]) + SW'(prod_a_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      dist_q <= dist_d;
      absd_q <= absd_d;
    end
  end

  // Outside when dist < -abs, straddling when dist < abs
  assign low_sum     = (SW+1)'(dist_q) + (SW+1)'(absd_q);
  assign high_diff   = (SW+1)'(dist_q) - (SW+1)'(absd_q);
  assign outside_o   = low_sum[SW];
  assign intersect_o = high_diff[SW];

endmodule

/* rtl/frustum_box_cull_unit.sv */
// A box verdict passes the snapshot, product, sum and output registers after acceptance.
// Throughput: one request per cycle; a stalled output holds the four-stage pipeline.
// Matrix load requests give no result and apply to every box accepted after them.
// Reset (rst_ni low, asynchronous): matrix cleared to zero, pipeline emptied.
// Each box snapshots its six planes at acceptance, so later loads never disturb it.
module frustum_box_cull_unit import fbc_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [1:0]                      column_i,
  input  logic signed [COORD_WIDTH-1:0]   element_row0_i,
  input  logic signed [COORD_WIDTH-1:0]   element_row1_i,
  input  logic signed [COORD_WIDTH-1:0]   element_row2_i,
  input  logic signed [COORD_WIDTH-1:0]   element_row3_i,
  input  logic signed [COORD_WIDTH-1:0]   box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0]   box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0]   box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      verdict_o
);

  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0] mat_q [MAT_DEPTH];

  logic in_accept;
  logic out_en;
  logic s3_en;
  logic s2_en;
  logic s1_en;
  logic s1_valid_q;
  logic s2_valid_q;
  logic s3_valid_q;
  logic out_valid_q;
  pipe_en_t pipe_en;

  logic signed [CW:0] coef_d    [PLANE_COUNT][ROW_COUNT];
  logic        [CW:0] abs_d     [PLANE_COUNT][AXIS_COUNT];
  logic signed [CW:0] csum_d    [AXIS_COUNT];
  logic signed [CW:0] cext_d    [AXIS_COUNT];
  logic signed [CW:0] s1_coef_q [PLANE_COUNT][ROW_COUNT];
  logic        [CW:0] s1_abs_q  [PLANE_COUNT][AXIS_COUNT];
  logic signed [CW:0] s1_csum_q [AXIS_COUNT];
  logic signed [CW:0] s1_cext_q [AXIS_COUNT];

  logic [PLANE_COUNT-1:0] outside_w;
  logic [PLANE_COUNT-1:0] intersect_w;
  verdict_e               verdict_d;
  verdict_e               verdict_q;

  // Advance each stage when it is empty or its successor advances
  assign out_en     = !out_valid_q || out_ready_i;
  assign s3_en      = !s3_valid_q || out_en;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;
  assign in_accept  = in_valid_i && in_ready_o;

  assign pipe_en.mul_en = s2_en;
  assign pipe_en.sum_en = s3_en;

  // Write one matrix column on a load request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_q[i] <= '0;
      end
    end else if (in_accept && kind_i == KIND_LOAD) begin
      mat_q[{column_i, 2'd0}] <= element_row0_i;
      mat_q[{column_i, 2'd1}] <= element_row1_i;
      mat_q[{column_i, 2'd2}] <= element_row2_i;
      mat_q[{column_i, 2'd3}] <= element_row3_i;
    end
  end

  // Build plane coefficients and their magnitudes from the matrix rows
  always_comb begin
    logic signed [CW:0] ea;
    logic signed [CW:0] eb;
    ea = '0;
    eb = '0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int c = 0; c < ROW_COUNT; c++) begin
        ea = (CW+1)'(mat_q[{2'(c), PLANE_ROW_A[p]}]);
        eb = (CW+1)'(mat_q[{2'(c), PLANE_ROW_B[p]}]);
        unique case (PLANE_OP[p])
          PAIR_ADD:  coef_d[p][c] = ea + eb;
          PAIR_SUB:  coef_d[p][c] = ea - eb;
          PAIR_NONE: coef_d[p][c] = ea;
          default:   coef_d[p][c] = ea;
        endcase
      end
      for (int k = 0; k < AXIS_COUNT; k++) begin
        abs_d[p][k] = coef_d[p][k][CW] ? (CW+1)'(-coef_d[p][k]) : (CW+1)'(coef_d[p][k]);
      end
    end
  end

  // Doubled centre and doubled extent of the box
  assign csum_d[0] = (CW+1)'(box_min_x_i) + (CW+1)'(box_max_x_i);
  assign csum_d[1] = (CW+1)'(box_min_y_i) + (CW+1)'(box_max_y_i);
  assign csum_d[2] = (CW+1)'(box_min_z_i) + (CW+1)'(box_max_z_i);
  assign cext_d[0] = (CW+1)'(box_max_x_i) - (CW+1)'(box_min_x_i);
  assign cext_d[1] = (CW+1)'(box_max_y_i) - (CW+1)'(box_min_y_i);
  assign cext_d[2] = (CW+1)'(box_max_z_i) - (CW+1)'(box_min_z_i);

  // Stage valids; only box requests enter the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i && kind_i == KIND_BOX;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Capture the box and its plane snapshot
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_coef_q <= coef_d;
      s1_abs_q  <= abs_d;
      s1_csum_q <= csum_d;
      s1_cext_q <= cext_d;
    end
  end

  // One evaluator per plane
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fbc_plane #(
      .COORD_WIDTH  (COORD_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_plane (
      .clk_i      (clk_i),
      .en_i       (pipe_en),
      .coef_i     (s1_coef_q[p]),
      .abs_i      (s1_abs_q[p]),
      .csum_i     (s1_csum_q),
      .cext_i     (s1_cext_q),
      .outside_o  (outside_w[p]),
      .intersect_o(intersect_w[p])
    );
  end

  // Outside on any plane wins over straddling any plane
  always_comb begin
    priority if (|outside_w) begin
      verdict_d = VERDICT_OUTSIDE;
    end else if (|intersect_w) begin
      verdict_d = VERDICT_INTERSECT;
    end else begin
      verdict_d = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

`ifndef SYNTH
  // A load request never enters the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && kind_i == KIND_LOAD |=> !s1_valid_q)
    else $error("load request entered the pipeline");

  // A box request always occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && kind_i == KIND_BOX |=> s1_valid_q)
    else $error("box request lost at entry");

  // Back-pressure only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q)
    else $error("input stalled with a bubble in the pipeline");

  // A full last stage is kept while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && out_valid_q && !out_ready_i |=> s3_valid_q)
    else $error("box dropped during output stall");
`endif

endmodule
